@@ hw/rtl/lsra_pkg.sv @@
// ---------------------------------------------------------------------------
// Linear scan register allocator package
// Shared sizes, cell entry and command types, and the free-register search.
// ---------------------------------------------------------------------------
package lsra_pkg;

   localparam int NUM_REGS  = 7;
   localparam int FIRST_REG = 4;
   localparam int POS_BITS  = 16;
   localparam int ID_BITS   = 10;
   localparam int REG_BITS  = 4;
   localparam int SLOT_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam logic [NUM_REGS-1:0] ALL_FREE = {NUM_REGS{1'b1}};

   // One entry of the active list.
   typedef struct packed {
      logic [POS_BITS-1:0]  end_pos;
      logic [SLOT_BITS-1:0] slot;
      logic [ID_BITS-1:0]   ident;
   } entry_type;

   // Operation applied to the whole row of cells at once.
   typedef struct packed {
      logic clear;
      logic pop;
      logic insert;
   } cell_cmd_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WORK
   } state_type;

   // Lowest set bit of the free mask.
   function automatic logic [SLOT_BITS-1:0] lowest_free(input logic [NUM_REGS-1:0] mask);
      logic [SLOT_BITS-1:0] slot;
      slot = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            slot = SLOT_BITS'(i);
         end
      end
      return slot;
   endfunction

endpackage

@@ hw/rtl/lsra_cell.sv @@
// ---------------------------------------------------------------------------
// Active list cell
// Holds one entry of the end-sorted active list and trades it with its
// neighbors on a pop (shift toward the front) or a sorted insert.
// ---------------------------------------------------------------------------
module lsra_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lsra_pkg::cell_cmd_type cmd,
   input  lsra_pkg::entry_type    new_entry,
   input  logic                   left_valid,
   input  lsra_pkg::entry_type    left_entry,
   input  logic                   left_gt,
   input  logic                   right_valid,
   input  lsra_pkg::entry_type    right_entry,
   output logic                   valid,
   output lsra_pkg::entry_type    entry,
   output logic                   gt
);

   logic                valid_ff;
   logic                valid_in;
   lsra_pkg::entry_type entry_ff;
   lsra_pkg::entry_type entry_in;

   // The new entry goes behind every entry whose end is not greater than its own.
   assign gt = !valid_ff || (entry_ff.end_pos > new_entry.end_pos);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.pop) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end else if (cmd.insert && gt) begin
         if (!left_gt) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end else begin
            valid_in = left_valid;
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

@@ hw/rtl/linear_scan_register_allocator.sv @@
// ---------------------------------------------------------------------------
// Linear scan register allocator
// Assigns physical registers to live intervals presented in start order.
// ---------------------------------------------------------------------------
// Usage: each req beat carries one live interval (id, start, end) and a
// new_pass flag that empties the active list, frees every register and
// clears the sticky failure flag before the interval is handled. Each req
// beat produces exactly one rsp beat with the assigned register, spill and
// eviction flags and the sticky pass_failed flag.
// An item goes through these steps in order: the req beat is taken, each
// active interval that expires at its start is popped as the row of cells
// shifts toward the front, and then the row does a sorted insert (dropping
// the last cell on eviction) unless the item spills, and the rsp register
// is loaded. req_ready is high only between items.
// The rsp register holds its beat until rsp_ready; while it is full the
// next item finishes its expiry and then waits for the register to empty.
// Reset empties the active list, frees all registers, clears the failure
// flag and drops rsp_valid.
// ---------------------------------------------------------------------------
module linear_scan_register_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_new_pass,
   input  logic [lsra_pkg::ID_BITS-1:0]     req_interval_id,
   input  logic [lsra_pkg::POS_BITS-1:0]    req_start_pos,
   input  logic [lsra_pkg::POS_BITS-1:0]    req_end_pos,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lsra_pkg::ID_BITS-1:0]     rsp_current_id,
   output logic [lsra_pkg::REG_BITS-1:0]    rsp_assigned_reg,
   output logic                             rsp_current_spilled,
   output logic                             rsp_evicted,
   output logic [lsra_pkg::ID_BITS-1:0]     rsp_evicted_id,
   output logic                             rsp_pass_failed
);

   localparam int N = lsra_pkg::NUM_REGS;

   lsra_pkg::state_type                   state_ff, state_in;
   logic [lsra_pkg::POS_BITS-1:0]         start_ff, start_in;
   lsra_pkg::entry_type                   item_ff, item_in;
   logic [N-1:0]                          free_ff, free_in;
   logic                                  failed_ff, failed_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lsra_pkg::ID_BITS-1:0]          cur_id_ff, cur_id_in;
   logic [lsra_pkg::REG_BITS-1:0]         reg_ff, reg_in;
   logic                                  spilled_ff, spilled_in;
   logic                                  evicted_ff, evicted_in;
   logic [lsra_pkg::ID_BITS-1:0]          ev_id_ff, ev_id_in;
   logic                                  rsp_failed_ff, rsp_failed_in;

   lsra_pkg::cell_cmd_type                cmd;
   logic                                  cell_valid [N];
   lsra_pkg::entry_type                   cell_entry [N];
   logic                                  cell_gt    [N];
   logic                                  lft_valid  [N];
   lsra_pkg::entry_type                   lft_entry  [N];
   logic                                  lft_gt     [N];
   logic                                  rgt_valid  [N];
   lsra_pkg::entry_type                   rgt_entry  [N];

   logic                                  req_fire;
   logic                                  pop_now;
   logic [lsra_pkg::SLOT_BITS-1:0]        free_slot;
   logic [lsra_pkg::SLOT_BITS-1:0]        use_slot;
   logic [lsra_pkg::REG_BITS:0]           reg_sum;
   lsra_pkg::entry_type                   ins_entry;

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lft_valid[i] = 1'b0;
         assign lft_entry[i] = '0;
         assign lft_gt[i]    = 1'b0;
      end else begin : g_mid
         assign lft_valid[i] = cell_valid[i-1];
         assign lft_entry[i] = cell_entry[i-1];
         assign lft_gt[i]    = cell_gt[i-1];
      end
      if (i == N - 1) begin : g_last
         assign rgt_valid[i] = 1'b0;
         assign rgt_entry[i] = '0;
      end else begin : g_inner
         assign rgt_valid[i] = cell_valid[i+1];
         assign rgt_entry[i] = cell_entry[i+1];
      end

      lsra_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_entry   (ins_entry),
         .left_valid  (lft_valid[i]),
         .left_entry  (lft_entry[i]),
         .left_gt     (lft_gt[i]),
         .right_valid (rgt_valid[i]),
         .right_entry (rgt_entry[i]),
         .valid       (cell_valid[i]),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i])
      );
   end

   assign req_ready = (state_ff == lsra_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign pop_now   = cell_valid[0] && (cell_entry[0].end_pos < start_ff);
   assign free_slot = lsra_pkg::lowest_free(free_ff);

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      item_in       = item_ff;
      free_in       = free_ff;
      failed_in     = failed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cur_id_in     = cur_id_ff;
      reg_in        = reg_ff;
      spilled_in    = spilled_ff;
      evicted_in    = evicted_ff;
      ev_id_in      = ev_id_ff;
      rsp_failed_in = rsp_failed_ff;
      cmd           = '0;
      use_slot      = free_slot;
      reg_sum       = '0;

      case (state_ff)
         lsra_pkg::ST_IDLE: begin
            if (req_fire) begin
               start_in      = req_start_pos;
               item_in.end_pos = req_end_pos;
               item_in.ident = req_interval_id;
               item_in.slot  = '0;
               if (req_new_pass) begin
                  cmd.clear = 1'b1;
                  free_in   = lsra_pkg::ALL_FREE;
                  failed_in = 1'b0;
               end
               state_in = lsra_pkg::ST_WORK;
            end
         end
         lsra_pkg::ST_WORK: begin
            if (pop_now) begin
               cmd.pop = 1'b1;
               for (int i = 0; i < N; i++) begin
                  if (cell_entry[0].slot == lsra_pkg::SLOT_BITS'(i)) begin
                     free_in[i] = 1'b1;
                  end
               end
            end else if (!rsp_valid_ff || rsp_ready) begin
               cur_id_in  = item_ff.ident;
               spilled_in = 1'b0;
               evicted_in = 1'b0;
               ev_id_in   = '0;
               reg_in     = '0;
               if (|free_ff) begin
                  use_slot   = free_slot;
                  cmd.insert = 1'b1;
                  for (int i = 0; i < N; i++) begin
                     if (free_slot == lsra_pkg::SLOT_BITS'(i)) begin
                        free_in[i] = 1'b0;
                     end
                  end
               end else if (cell_entry[N-1].end_pos > item_ff.end_pos) begin
                  // No free register means the row is full; the last cell
                  // falls off the end of the shift and hands over its register.
                  use_slot   = cell_entry[N-1].slot;
                  cmd.insert = 1'b1;
                  evicted_in = 1'b1;
                  ev_id_in   = cell_entry[N-1].ident;
                  failed_in  = 1'b1;
               end else begin
                  spilled_in = 1'b1;
                  failed_in  = 1'b1;
               end
               if (cmd.insert) begin
                  reg_sum = (lsra_pkg::REG_BITS + 1)'(lsra_pkg::FIRST_REG)
                          + (lsra_pkg::REG_BITS + 1)'(use_slot);
                  reg_in  = reg_sum[lsra_pkg::REG_BITS-1:0];
               end
               // The flag is captured with the beat, since a new pass may
               // clear the live flag while this beat still waits.
               rsp_failed_in = failed_in;
               rsp_valid_in  = 1'b1;
               state_in      = lsra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsra_pkg::ST_IDLE;
         end
      endcase
   end

   // The slot travels with the new entry into the row on the insert cycle.
   always_comb begin
      ins_entry      = item_ff;
      ins_entry.slot = use_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsra_pkg::ST_IDLE;
         free_ff      <= lsra_pkg::ALL_FREE;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff      <= start_in;
      item_ff       <= (state_ff == lsra_pkg::ST_WORK) ? ins_entry : item_in;
      cur_id_ff     <= cur_id_in;
      reg_ff        <= reg_in;
      spilled_ff    <= spilled_in;
      evicted_ff    <= evicted_in;
      ev_id_ff      <= ev_id_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_current_id      = cur_id_ff;
   assign rsp_assigned_reg    = reg_ff;
   assign rsp_current_spilled = spilled_ff;
   assign rsp_evicted         = evicted_ff;
   assign rsp_evicted_id      = ev_id_ff;
   assign rsp_pass_failed     = rsp_failed_ff;

endmodule

@@ hw/rtl/lsra_checker.sv @@
// ---------------------------------------------------------------------------
// Linear scan register allocator checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module lsra_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_new_pass,
   input logic [lsra_pkg::ID_BITS-1:0]     req_interval_id,
   input logic [lsra_pkg::POS_BITS-1:0]    req_start_pos,
   input logic [lsra_pkg::POS_BITS-1:0]    req_end_pos,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lsra_pkg::ID_BITS-1:0]     rsp_current_id,
   input logic [lsra_pkg::REG_BITS-1:0]    rsp_assigned_reg,
   input logic                             rsp_current_spilled,
   input logic                             rsp_evicted,
   input logic [lsra_pkg::ID_BITS-1:0]     rsp_evicted_id,
   input logic                             rsp_pass_failed
);

   // A spilled interval gets no register.
   a_spill_no_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_current_spilled |-> rsp_assigned_reg == '0)
      else $error("spilled interval reports a register");

   // The current interval cannot be both spilled and the winner of an eviction.
   a_spill_xor_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_current_spilled && rsp_evicted))
      else $error("spill and eviction in one beat");

   // Any spill in this beat must show in the sticky flag.
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_current_spilled || rsp_evicted) |-> rsp_pass_failed)
      else $error("spill without pass_failed");

   // Without an eviction the evicted id reads as zero.
   a_no_evict_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_id == '0)
      else $error("evicted id without eviction");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_id)
         && $stable(rsp_assigned_reg))
      else $error("result beat changed while stalled");

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (.*);
